// ===== rtl/core/dqso_pkg.sv =====
// package: payload types, constants and step function of the dual quadrature odometer
package dqso_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int FIELD_WIDTH     = 16;
	localparam int PERIOD_WIDTH    = 16;
	localparam int CFG_ADDR_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH  = 32;

	localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd77;

	// register index, taken from paddr[2]
	localparam logic REG_SAMPLE_PERIOD = 1'b0;

	typedef struct packed {
		logic first_a_edge;
		logic first_b_edge;
		logic second_a_edge;
		logic second_b_edge;
		logic first_a_level;
		logic first_b_level;
		logic second_a_level;
		logic second_b_level;
	} dqso_in_t;

	typedef struct packed {
		logic signed [FIELD_WIDTH-1:0] first_speed;
		logic signed [FIELD_WIDTH-1:0] second_speed;
		logic signed [FIELD_WIDTH-1:0] distance;
		logic                          sample_taken;
	} dqso_out_t;

	// x2 decode: net count change of one encoder for one event, -2..2
	function automatic logic signed [2:0] edge_step(input logic a_edge, input logic b_edge,
	                                                input logic a_lvl, input logic b_lvl);
		logic signed [2:0] step;
		logic              diff;
		diff = a_lvl ^ b_lvl;
		step = 3'sd0;
		if (a_edge) begin
			step = diff ? step + 3'sd1 : step - 3'sd1;
		end
		if (b_edge) begin
			step = diff ? step - 3'sd1 : step + 3'sd1;
		end
		return step;
	endfunction

endpackage

// ===== rtl/core/dqso_if.sv =====
// interfaces: valid/ready channels for edge events and odometer results
interface dqso_in_if import dqso_pkg::*; ();
	logic     valid;
	logic     ready;
	dqso_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dqso_out_if import dqso_pkg::*; ();
	logic      valid;
	logic      ready;
	dqso_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/dual_quadrature_speed_odometer.sv =====
// top level: dual quadrature encoder x2 decoder with speed sampling and distance
//
//  channel   direction  handshake              payload
//  in_ch     sink       valid/ready            edge flags and pin levels
//  out_ch    source     valid/ready            speeds, distance, sample_taken
//  apb       slave      psel/penable/pready    sample_period at byte address 0
//
// one edge event per cycle sustained while out_ch is not stalled; a result passes through the
// input register, then the update of counts, speeds and distance into the result register
// arst_n clears the counts, event counter, speeds and distance and sets sample_period to 77
// a stalled output holds the result register; the input register then fills and in_ch.ready drops
module dual_quadrature_speed_odometer import dqso_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	dqso_in_if.sink                   in_ch,
	dqso_out_if.source                out_ch
);

	logic [PERIOD_WIDTH-1:0] sample_period_q;
	logic [COUNT_WIDTH-1:0]  first_count_q;
	logic [COUNT_WIDTH-1:0]  second_count_q;
	logic [PERIOD_WIDTH-1:0] event_count_q;
	logic [COUNT_WIDTH-1:0]  first_speed_q;
	logic [COUNT_WIDTH-1:0]  second_speed_q;
	logic [COUNT_WIDTH-1:0]  distance_q;

	dqso_in_t  item_s1;
	logic      valid_s1;
	dqso_out_t result_q;
	logic      out_valid_q;

	logic                    advance;
	logic                    cfg_write;
	logic signed [2:0]       first_step;
	logic signed [2:0]       second_step;
	logic [COUNT_WIDTH-1:0]  first_count_nx;
	logic [COUNT_WIDTH-1:0]  second_count_nx;
	logic [PERIOD_WIDTH-1:0] event_count_nx;
	logic                    hit;
	logic [COUNT_WIDTH-1:0]  first_neg;
	logic [COUNT_WIDTH-1:0]  second_neg;
	logic [COUNT_WIDTH:0]    speed_sum;
	logic [COUNT_WIDTH:0]    speed_sum_adj;
	logic [COUNT_WIDTH-1:0]  first_speed_nx;
	logic [COUNT_WIDTH-1:0]  second_speed_nx;
	logic [COUNT_WIDTH-1:0]  distance_nx;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_PERIOD);
	assign prdata    = (paddr[2] == REG_SAMPLE_PERIOD) ?
	                   CFG_DATA_WIDTH'(sample_period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= PERIOD_RESET;
		end else if (cfg_write) begin
			sample_period_q <= pwdata[PERIOD_WIDTH-1:0];
		end
	end

	// pipeline control
	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	// event update
	always_comb begin
		first_step = edge_step(item_s1.first_a_edge, item_s1.first_b_edge,
		                       item_s1.first_a_level, item_s1.first_b_level);
		second_step = edge_step(item_s1.second_a_edge, item_s1.second_b_edge,
		                        item_s1.second_a_level, item_s1.second_b_level);
		first_count_nx  = first_count_q + COUNT_WIDTH'(first_step);
		second_count_nx = second_count_q + COUNT_WIDTH'(second_step);
		event_count_nx  = event_count_q + PERIOD_WIDTH'(1);
		hit             = (event_count_nx == sample_period_q);

		first_neg  = -first_count_nx;
		second_neg = -second_count_nx;
		// half-sum truncated toward zero
		speed_sum     = {first_neg[COUNT_WIDTH-1], first_neg}
		              + {second_neg[COUNT_WIDTH-1], second_neg};
		speed_sum_adj = speed_sum + {{COUNT_WIDTH{1'b0}}, speed_sum[COUNT_WIDTH]};

		first_speed_nx  = hit ? first_neg : first_speed_q;
		second_speed_nx = hit ? second_neg : second_speed_q;
		distance_nx     = hit ? distance_q + speed_sum_adj[COUNT_WIDTH:1] : distance_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			event_count_q  <= '0;
			first_speed_q  <= '0;
			second_speed_q <= '0;
			distance_q     <= '0;
		end else if (valid_s1 && advance) begin
			first_count_q  <= hit ? '0 : first_count_nx;
			second_count_q <= hit ? '0 : second_count_nx;
			event_count_q  <= hit ? '0 : event_count_nx;
			first_speed_q  <= first_speed_nx;
			second_speed_q <= second_speed_nx;
			distance_q     <= distance_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q.first_speed  <= FIELD_WIDTH'(first_speed_nx);
			result_q.second_speed <= FIELD_WIDTH'(second_speed_nx);
			result_q.distance     <= FIELD_WIDTH'(distance_nx);
			result_q.sample_taken <= hit;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = result_q;

endmodule

// ===== rtl/core/dqso_checker.sv =====
// checker: port-level assertions for the dual quadrature odometer, bound to the top level
module dqso_checker import dqso_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input dqso_out_t out_data
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result payload changed while stalled");

	// input only backs up behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input not ready without output stall");

	// every input transfer yields a pending result after the input and result registers
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing after input transfer");

	// speeds and distance change only on a sample
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) ##1 (out_valid && out_ready && !out_data.sample_taken)
		|-> $stable(out_data.first_speed) && $stable(out_data.second_speed)
		    && $stable(out_data.distance))
		else $error("speed or distance changed without a sample");

endmodule

bind dual_quadrature_speed_odometer dqso_checker u_dqso_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
